// ===== rtl/core/per_source_quota_tracker_defines.svh =====
// Assertion macros shared by the quota tracker checker.
`ifndef PER_SOURCE_QUOTA_TRACKER_DEFINES_SVH
`define PER_SOURCE_QUOTA_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PSQT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSQT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/psqt_pkg.sv =====
// Shared constants, types and helper function of the quota tracker.
package psqt_pkg;

   // Sizing
   localparam int SOURCES    = 32;
   localparam int TYPES      = 11;
   localparam int COUNT_BITS = 16;
   localparam int LIMIT_BITS = 12;
   localparam int LIMS_PER_REG = 5;
   localparam int SRC_IW     = (SOURCES > 1) ? $clog2(SOURCES) : 1;
   localparam int TYPE_IW    = (TYPES > 1) ? $clog2(TYPES) : 1;

   // Request / response field widths
   localparam int KIND_BITS     = 3;
   localparam int SLOT_BITS     = 6;
   localparam int TYPE_BITS     = 4;
   localparam int REPORT_BITS   = 16;
   localparam int CAUSE_BITS    = 2;
   localparam int REQ_DATA_BITS = 16;
   localparam int RSP_DATA_BITS = 40;

   // Register port
   localparam int CSR_AW   = 6;
   localparam int CSR_DW   = 64;
   localparam int REG_BITS = LIMIT_BITS * LIMS_PER_REG;
   localparam int REG_IDX_BITS = 3;

   // Request queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QP_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QL_BITS     = $clog2(QUEUE_DEPTH + 1);

   // Request kind codes as they arrive on the bus
   localparam logic [KIND_BITS-1:0] KIND_CHECK   = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_ACQUIRE = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_RELEASE = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_CLR_SRC = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_CLR_ALL = 3'd4;

   // Deny causes
   localparam logic [CAUSE_BITS-1:0] CAUSE_NONE   = 2'd0;
   localparam logic [CAUSE_BITS-1:0] CAUSE_GLOBAL = 2'd1;
   localparam logic [CAUSE_BITS-1:0] CAUSE_SOURCE = 2'd2;

   // Register indexes
   localparam logic [REG_IDX_BITS-1:0] REG_ENABLED        = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_GLOBAL_LIMITS_A = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_GLOBAL_LIMITS_B = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_GLOBAL_LIMIT_C  = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_SOURCE_LIMITS_A = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_SOURCE_LIMITS_B = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_SOURCE_LIMIT_C  = 3'd6;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef count_type [TYPES-1:0] row_type;
   typedef logic [LIMIT_BITS-1:0] limit_type;

   localparam count_type COUNT_MAX = '1;

   // Decoded operation
   typedef enum logic [2:0] {
      OP_CHECK,
      OP_ACQUIRE,
      OP_RELEASE,
      OP_CLR_SRC,
      OP_CLR_ALL,
      OP_NOP
   } op_kind_type;

   // One classified request as it travels through the queue
   typedef struct packed {
      op_kind_type        op;
      logic [SRC_IW-1:0]  slot;
      logic [TYPE_IW-1:0] rtype;
      logic               slot_ok;
      logic               type_ok;
   } op_type;

   // Configuration register file contents
   typedef struct packed {
      logic                enabled;
      logic [REG_BITS-1:0] glim_a;
      logic [REG_BITS-1:0] glim_b;
      limit_type           glim_c;
      logic [REG_BITS-1:0] slim_a;
      logic [REG_BITS-1:0] slim_b;
      limit_type           slim_c;
   } cfg_type;

   // Response payload, allowed in the lowest bit
   typedef struct packed {
      logic [REPORT_BITS-1:0] gcount;
      logic [REPORT_BITS-1:0] scount;
      logic [CAUSE_BITS-1:0]  cause;
      logic                   allowed;
   } rsp_type;

   localparam int RSP_PAD = RSP_DATA_BITS - $bits(rsp_type);

   // Pick the 12-bit limit of one type out of the packed registers
   function automatic limit_type limit_of(logic [REG_BITS-1:0] a, logic [REG_BITS-1:0] b,
                                          limit_type c, logic [TYPE_IW-1:0] t);
      limit_type lim;
      lim = '0;
      if (32'(t) < LIMS_PER_REG) begin
         lim = a[LIMIT_BITS*32'(t) +: LIMIT_BITS];
      end else if (32'(t) < 2*LIMS_PER_REG) begin
         lim = b[LIMIT_BITS*(32'(t)-LIMS_PER_REG) +: LIMIT_BITS];
      end else if (32'(t) == 2*LIMS_PER_REG) begin
         lim = c;
      end
      return lim;
   endfunction

endpackage

// ===== rtl/core/psqt_csr.sv =====
// Configuration registers of the quota tracker behind an APB-style port.
module psqt_csr import psqt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type                 cfg_ff, cfg_in;
   logic [REG_IDX_BITS-1:0] reg_idx;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_AW-1:3];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ENABLED:         cfg_in.enabled = csr_pwdata[0];
            REG_GLOBAL_LIMITS_A: cfg_in.glim_a  = csr_pwdata[REG_BITS-1:0];
            REG_GLOBAL_LIMITS_B: cfg_in.glim_b  = csr_pwdata[REG_BITS-1:0];
            REG_GLOBAL_LIMIT_C:  cfg_in.glim_c  = csr_pwdata[LIMIT_BITS-1:0];
            REG_SOURCE_LIMITS_A: cfg_in.slim_a  = csr_pwdata[REG_BITS-1:0];
            REG_SOURCE_LIMITS_B: cfg_in.slim_b  = csr_pwdata[REG_BITS-1:0];
            REG_SOURCE_LIMIT_C:  cfg_in.slim_c  = csr_pwdata[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled <= 1'b1;
         cfg_ff.glim_a  <= 60'd84476856107828200;
         cfg_ff.glim_b  <= 60'd5636372321362020;
         cfg_ff.glim_c  <= 12'd200;
         cfg_ff.slim_a  <= 60'd8447685610782820;
         cfg_ff.slim_b  <= 60'd563637232136202;
         cfg_ff.slim_c  <= 12'd20;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         REG_ENABLED:         csr_prdata = CSR_DW'(cfg_ff.enabled);
         REG_GLOBAL_LIMITS_A: csr_prdata = CSR_DW'(cfg_ff.glim_a);
         REG_GLOBAL_LIMITS_B: csr_prdata = CSR_DW'(cfg_ff.glim_b);
         REG_GLOBAL_LIMIT_C:  csr_prdata = CSR_DW'(cfg_ff.glim_c);
         REG_SOURCE_LIMITS_A: csr_prdata = CSR_DW'(cfg_ff.slim_a);
         REG_SOURCE_LIMITS_B: csr_prdata = CSR_DW'(cfg_ff.slim_b);
         REG_SOURCE_LIMIT_C:  csr_prdata = CSR_DW'(cfg_ff.slim_c);
         default:             csr_prdata = '0;
      endcase
   end

endmodule

// ===== rtl/core/psqt_front.sv =====
// Request intake: accepts requests and classifies them into queue operations.
module psqt_front import psqt_pkg::*; (
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // [5:0] source_slot, [9:6] resource_type
   input  logic [KIND_BITS-1:0]     req_tuser,  // [2:0] kind
   input  logic                     q_full,
   output logic                     q_push,
   output op_type                   q_op
);

   logic [SLOT_BITS-1:0] slot;
   logic [TYPE_BITS-1:0] rtype;
   logic                 slot_ok;
   logic                 type_ok;

   assign slot    = req_tdata[SLOT_BITS-1:0];
   assign rtype   = req_tdata[SLOT_BITS +: TYPE_BITS];
   assign slot_ok = 32'(slot) < SOURCES;
   assign type_ok = 32'(rtype) < TYPES;

   assign req_tready = ~q_full;
   assign q_push     = req_tvalid & ~q_full;

   // Classify; out-of-range indexes are forced to zero so the back end never
   // addresses past its stores
   always_comb begin
      case (req_tuser)
         KIND_CHECK:   q_op.op = OP_CHECK;
         KIND_ACQUIRE: q_op.op = OP_ACQUIRE;
         KIND_RELEASE: q_op.op = OP_RELEASE;
         KIND_CLR_SRC: q_op.op = OP_CLR_SRC;
         KIND_CLR_ALL: q_op.op = OP_CLR_ALL;
         default:      q_op.op = OP_NOP;
      endcase
      q_op.slot    = slot_ok ? slot[SRC_IW-1:0] : '0;
      q_op.rtype   = type_ok ? rtype[TYPE_IW-1:0] : '0;
      q_op.slot_ok = slot_ok;
      q_op.type_ok = type_ok;
   end

endmodule

// ===== rtl/core/psqt_fifo.sv =====
// Short queue of classified operations between intake and execution.
module psqt_fifo import psqt_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output op_type pop_op,
   output logic   not_empty
);

   op_type               entries_ff [QUEUE_DEPTH];
   logic [QP_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QP_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QL_BITS-1:0]   level_ff, level_in;
   logic                 do_push, do_pop;

   assign full      = level_ff == QL_BITS'(QUEUE_DEPTH);
   assign not_empty = level_ff != '0;
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;
   assign pop_op    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QP_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + QP_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QP_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + QP_BITS'(1);
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + QL_BITS'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - QL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== rtl/core/psqt_back.sv =====
// Execution engine: per-source count memory, global counts and result register.
module psqt_back import psqt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     op_valid,
   input  op_type                   op_head,
   output logic                     op_pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata  // [0] allowed, [2:1] deny_cause,
                                               // [18:3] source_count, [34:19] global_count
);

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   // One row per source holds all of its type counts
   row_type              mem [SOURCES];
   row_type              row_rd_ff;

   state_type            state_ff, state_in;
   op_type               cur_ff, cur_in;
   logic [SOURCES-1:0]   row_valid_ff, row_valid_in, row_valid_nx;
   row_type              glob_ff, glob_in, glob_nx;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in, rsp_nx;

   row_type              row_eff;
   row_type              wr_row;
   logic                 mem_we, mem_we_nx;
   logic                 commit;
   logic                 both_ok;
   count_type            fld, gcnt, new_f, new_g;
   limit_type            glim, slim;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_ff};

   assign op_pop  = (state_ff == ST_IDLE) && op_valid;
   assign commit  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign both_ok = cur_ff.slot_ok && cur_ff.type_ok;

   // Operands of the current operation; a row never written since its last
   // clear reads as zero
   assign row_eff = row_valid_ff[cur_ff.slot] ? row_rd_ff : '0;
   assign fld     = row_eff[cur_ff.rtype];
   assign gcnt    = glob_ff[cur_ff.rtype];
   assign glim    = limit_of(cfg.glim_a, cfg.glim_b, cfg.glim_c, cur_ff.rtype);
   assign slim    = limit_of(cfg.slim_a, cfg.slim_b, cfg.slim_c, cur_ff.rtype);

   // Execute one operation
   always_comb begin
      row_valid_nx   = row_valid_ff;
      glob_nx        = glob_ff;
      mem_we_nx      = 1'b0;
      wr_row         = row_eff;
      new_f          = fld;
      new_g          = gcnt;
      rsp_nx.allowed = 1'b1;
      rsp_nx.cause   = CAUSE_NONE;
      if (cfg.enabled) begin
         case (cur_ff.op)
            OP_CHECK: begin
               if (both_ok) begin
                  if (glim != '0 && 32'(gcnt) >= 32'(glim)) begin
                     rsp_nx.allowed = 1'b0;
                     rsp_nx.cause   = CAUSE_GLOBAL;
                  end else if (slim != '0 && 32'(fld) >= 32'(slim)) begin
                     rsp_nx.allowed = 1'b0;
                     rsp_nx.cause   = CAUSE_SOURCE;
                  end
               end
            end
            OP_ACQUIRE: begin
               if (both_ok) begin
                  new_f = (fld == COUNT_MAX) ? fld : fld + COUNT_BITS'(1);
                  new_g = (gcnt == COUNT_MAX) ? gcnt : gcnt + COUNT_BITS'(1);
                  wr_row[cur_ff.rtype]       = new_f;
                  glob_nx[cur_ff.rtype]      = new_g;
                  row_valid_nx[cur_ff.slot]  = 1'b1;
                  mem_we_nx                  = 1'b1;
               end
            end
            OP_RELEASE: begin
               if (both_ok) begin
                  new_f = (fld == '0) ? fld : fld - COUNT_BITS'(1);
                  new_g = (gcnt == '0) ? gcnt : gcnt - COUNT_BITS'(1);
                  wr_row[cur_ff.rtype]       = new_f;
                  glob_nx[cur_ff.rtype]      = new_g;
                  row_valid_nx[cur_ff.slot]  = 1'b1;
                  mem_we_nx                  = 1'b1;
               end
            end
            OP_CLR_SRC: begin
               // Whole row comes back from the memory: take every type off the
               // global counts at once, flooring at zero
               if (cur_ff.slot_ok) begin
                  for (int t = 0; t < TYPES; t++) begin
                     glob_nx[t] = (glob_ff[t] > row_eff[t]) ? glob_ff[t] - row_eff[t] : '0;
                  end
                  row_valid_nx[cur_ff.slot] = 1'b0;
                  new_f = '0;
                  new_g = glob_nx[cur_ff.rtype];
               end
            end
            OP_CLR_ALL: begin
               row_valid_nx = '0;
               glob_nx      = '0;
               new_f        = '0;
               new_g        = '0;
            end
            default: ;
         endcase
      end
      rsp_nx.scount = both_ok ? REPORT_BITS'(new_f) : '0;
      rsp_nx.gcount = cur_ff.type_ok ? REPORT_BITS'(new_g) : '0;
   end

   // Next-state selection
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      row_valid_in = row_valid_ff;
      glob_in      = glob_ff;
      mem_we       = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (op_pop) begin
               cur_in   = op_head;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               row_valid_in = row_valid_nx;
               glob_in      = glob_nx;
               mem_we       = mem_we_nx;
               rsp_in       = rsp_nx;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_valid_ff <= '0;
         glob_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         glob_ff      <= glob_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   // Count memory: row read when an operation is taken, row write on commit
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cur_ff.slot] <= wr_row;
      end
      if (op_pop) begin
         row_rd_ff <= mem[op_head.slot];
      end
   end

endmodule

// ===== rtl/core/per_source_quota_tracker.sv =====
// Two-level quota tracker: per-source and global counts per resource type.
// Requests (check, acquire, release, clear-source, clear-all) are taken by an
// intake stage into a two-entry queue and executed by a back end that keeps
// all type counts of one source in one row of a 32-row memory. Each request
// goes through a row-read step and then a compare/update/write step in the
// back end, which takes no new request until the last one has committed;
// the compare/update/write step also waits while the result register is full.
// Clear-source and clear-all finish in those same steps: rows are marked
// invalid by per-source valid bits and the global counts sit in flip-flops,
// so there is no clearing pass.
// Configuration registers sit at byte address 8*i and should only be written
// while no request is outstanding.
module per_source_quota_tracker import psqt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // [5:0] source_slot, [9:6] resource_type
   input  logic [KIND_BITS-1:0]     req_tuser,   // [2:0] kind
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [0] allowed, [2:1] deny_cause,
                                                 // [18:3] source_count, [34:19] global_count
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_AW-1:0]        csr_paddr,
   input  logic [CSR_DW-1:0]        csr_pwdata,
   output logic [CSR_DW-1:0]        csr_prdata,
   output logic                     csr_pready
);

   cfg_type cfg;
   logic    q_full, q_push, q_pop, q_not_empty;
   op_type  q_in_op, q_out_op;

   psqt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   psqt_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_op       (q_in_op)
   );

   psqt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_op   (q_in_op),
      .full      (q_full),
      .pop       (q_pop),
      .pop_op    (q_out_op),
      .not_empty (q_not_empty)
   );

   psqt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .op_valid   (q_not_empty),
      .op_head    (q_out_op),
      .op_pop     (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/core/psqt_checker.sv =====
// Port-level checks on the quota tracker response channel, bound to the top.
`include "per_source_quota_tracker_defines.svh"

module psqt_checker import psqt_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   rsp_type r;

   assign r = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);

   // A stalled response stays put
   `PSQT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // Allowed and deny cause agree, and the cause is a known code
   `PSQT_ASSERT_SAME(a_cause_match, clock, reset, rsp_tvalid,
                     (r.allowed == (r.cause == CAUSE_NONE)) &&
                     (r.cause == CAUSE_NONE || r.cause == CAUSE_GLOBAL ||
                      r.cause == CAUSE_SOURCE), "allowed and deny cause disagree")

   // A global denial needs a nonzero global count
   `PSQT_ASSERT_SAME(a_global_deny, clock, reset, rsp_tvalid && r.cause == CAUSE_GLOBAL,
                     r.gcount != '0, "global denial with zero global count")

   // A per-source denial needs a nonzero source count
   `PSQT_ASSERT_SAME(a_source_deny, clock, reset, rsp_tvalid && r.cause == CAUSE_SOURCE,
                     r.scount != '0, "source denial with zero source count")

endmodule

bind per_source_quota_tracker psqt_checker u_psqt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/tb_per_source_quota_tracker.sv =====
// Testbench for the quota tracker: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module tb_per_source_quota_tracker;
   import psqt_pkg::*;

   localparam int CLOCK_HALF        = 5;
   localparam int RESET_CYCLES      = 3;
   localparam int RUN_LIMIT         = 1_000_000;
   localparam int SETTLE_CYCLES     = 8;
   localparam int RANDOM_REQUESTS   = 180;
   localparam int ACQUIRE_RUN       = 24;

   // Kind codes the block does not define; it treats them as allowed no-ops
   localparam logic [KIND_BITS-1:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [KIND_BITS-1:0] KIND_SPARE_LAST  = 3'd7;

   localparam limit_type LIMIT_NONE = '0;
   localparam limit_type LIMIT_TOP  = '1;

   typedef enum int {LIMS_ZERO, LIMS_TOP, LIMS_TIGHT, LIMS_ANY} limit_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;   // [5:0] source_slot, [9:6] resource_type
   logic [KIND_BITS-1:0]     req_tuser = '0;   // [2:0] kind
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;       // [0] allowed, [2:1] deny_cause,
                                              // [18:3] source_count, [34:19] global_count
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]        csr_paddr = '0;
   logic [CSR_DW-1:0]        csr_pwdata = '0;
   logic [CSR_DW-1:0]        csr_prdata;
   logic                     csr_pready;

   // Predictor copy of the registers and counts
   logic                cfg_enabled;
   logic [REG_BITS-1:0] cfg_glim_a, cfg_glim_b, cfg_slim_a, cfg_slim_b;
   limit_type           cfg_glim_c, cfg_slim_c;
   count_type           src_count [SOURCES][TYPES];
   count_type           glb_count [TYPES];

   rsp_type     pending_results[$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   per_source_quota_tracker uut (.*);

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Limit of one type out of the packed registers
   function automatic limit_type lookup_limit(logic [REG_BITS-1:0] a, logic [REG_BITS-1:0] b,
                                              limit_type c, int t);
      logic [2*REG_BITS+LIMIT_BITS-1:0] all_limits;
      all_limits = {c, b, a};
      return all_limits[LIMIT_BITS*t +: LIMIT_BITS];
   endfunction

   // Apply one request to the predicted counts and return the expected response
   function automatic rsp_type predict_quota(logic [KIND_BITS-1:0] kind,
                                             logic [SLOT_BITS-1:0] slot,
                                             logic [TYPE_BITS-1:0] rtype);
      rsp_type   res;
      logic      slot_ok, type_ok;
      limit_type glim, slim;
      int        s, t;
      s = int'(slot);
      t = int'(rtype);
      slot_ok = (s < SOURCES);
      type_ok = (t < TYPES);
      res = '0;
      res.allowed = 1'b1;
      res.cause = CAUSE_NONE;
      if (cfg_enabled) begin
         case (kind)
            KIND_CHECK: begin
               if (slot_ok && type_ok) begin
                  glim = lookup_limit(cfg_glim_a, cfg_glim_b, cfg_glim_c, t);
                  slim = lookup_limit(cfg_slim_a, cfg_slim_b, cfg_slim_c, t);
                  // global limit takes priority over the per-source one
                  if (glim != LIMIT_NONE && glb_count[t] >= glim) begin
                     res.allowed = 1'b0;
                     res.cause = CAUSE_GLOBAL;
                  end else if (slim != LIMIT_NONE && src_count[s][t] >= slim) begin
                     res.allowed = 1'b0;
                     res.cause = CAUSE_SOURCE;
                  end
               end
            end
            KIND_ACQUIRE: begin
               if (slot_ok && type_ok) begin
                  if (src_count[s][t] != COUNT_MAX) src_count[s][t]++;
                  if (glb_count[t] != COUNT_MAX) glb_count[t]++;
               end
            end
            KIND_RELEASE: begin
               if (slot_ok && type_ok) begin
                  if (src_count[s][t] != '0) src_count[s][t]--;
                  if (glb_count[t] != '0) glb_count[t]--;
               end
            end
            KIND_CLR_SRC: begin
               // type is not used; global count floors at zero
               if (slot_ok) begin
                  for (int i = 0; i < TYPES; i++) begin
                     glb_count[i] = (glb_count[i] > src_count[s][i]) ?
                                    glb_count[i] - src_count[s][i] : '0;
                     src_count[s][i] = '0;
                  end
               end
            end
            KIND_CLR_ALL: begin
               for (int i = 0; i < TYPES; i++) begin
                  glb_count[i] = '0;
                  for (int j = 0; j < SOURCES; j++) src_count[j][i] = '0;
               end
            end
            default: ;
         endcase
      end
      if (type_ok) begin
         res.gcount = glb_count[t];
         if (slot_ok) res.scount = src_count[s][t];
      end
      return res;
   endfunction

   task automatic flag_field(string field, longint unsigned want, longint unsigned got);
      mismatch_count++;
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
   endtask

   // Response checker
   always @(posedge clock) begin : rsp_check
      rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $error("response with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            if (got.allowed !== want.allowed)
               flag_field("allowed", 64'(want.allowed), 64'(got.allowed));
            if (got.cause !== want.cause)
               flag_field("deny_cause", 64'(want.cause), 64'(got.cause));
            if (got.scount !== want.scount)
               flag_field("source_count", 64'(want.scount), 64'(got.scount));
            if (got.gcount !== want.gcount)
               flag_field("global_count", 64'(want.gcount), 64'(got.gcount));
         end
      end
   end

   // Send one request; valid stays high between back-to-back requests
   task automatic send_request(logic [KIND_BITS-1:0] kind, logic [SLOT_BITS-1:0] slot,
                               logic [TYPE_BITS-1:0] rtype);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= REQ_DATA_BITS'({rtype, slot});
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_quota(kind, slot, rtype));
   endtask

   // Stop sending and wait for every outstanding response
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup then access cycle
   task automatic csr_write(logic [REG_IDX_BITS-1:0] idx, logic [CSR_DW-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(8 * idx);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_ENABLED:         cfg_enabled = value[0];
         REG_GLOBAL_LIMITS_A: cfg_glim_a = value[REG_BITS-1:0];
         REG_GLOBAL_LIMITS_B: cfg_glim_b = value[REG_BITS-1:0];
         REG_GLOBAL_LIMIT_C:  cfg_glim_c = value[LIMIT_BITS-1:0];
         REG_SOURCE_LIMITS_A: cfg_slim_a = value[REG_BITS-1:0];
         REG_SOURCE_LIMITS_B: cfg_slim_b = value[REG_BITS-1:0];
         REG_SOURCE_LIMIT_C:  cfg_slim_c = value[LIMIT_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Limit word of a given style; bits above the fields are random
   function automatic logic [CSR_DW-1:0] limit_word(limit_mode_type mode);
      logic [CSR_DW-1:0] w;
      w = {$urandom, $urandom};
      for (int i = 0; i < LIMS_PER_REG; i++) begin
         case (mode)
            LIMS_ZERO:  w[LIMIT_BITS*i +: LIMIT_BITS] = LIMIT_NONE;
            LIMS_TOP:   w[LIMIT_BITS*i +: LIMIT_BITS] = LIMIT_TOP;
            LIMS_TIGHT: w[LIMIT_BITS*i +: LIMIT_BITS] = ($urandom_range(3) == 0) ?
                                                        LIMIT_NONE :
                                                        limit_type'($urandom_range(1, 4));
            default: ;
         endcase
      end
      return w;
   endfunction

   task automatic program_limits(limit_mode_type gmode, limit_mode_type smode);
      csr_write(REG_ENABLED, CSR_DW'(1));
      csr_write(REG_GLOBAL_LIMITS_A, limit_word(gmode));
      csr_write(REG_GLOBAL_LIMITS_B, limit_word(gmode));
      csr_write(REG_GLOBAL_LIMIT_C, limit_word(gmode));
      csr_write(REG_SOURCE_LIMITS_A, limit_word(smode));
      csr_write(REG_SOURCE_LIMITS_B, limit_word(smode));
      csr_write(REG_SOURCE_LIMIT_C, limit_word(smode));
   endtask

   // Every operation at field extremes, out-of-range slot and type, spare kinds
   task automatic test_basic_ops();
      send_request(KIND_CHECK, 0, 0);
      send_request(KIND_ACQUIRE, 0, 0);
      send_request(KIND_ACQUIRE, 0, 0);
      send_request(KIND_RELEASE, 0, 0);
      send_request(KIND_RELEASE, 4, 4);
      send_request(KIND_ACQUIRE, SLOT_BITS'(SOURCES - 1), TYPE_BITS'(TYPES - 1));
      send_request(KIND_ACQUIRE, '1, 3);
      send_request(KIND_ACQUIRE, 2, '1);
      send_request(KIND_CHECK, SLOT_BITS'(SOURCES), TYPE_BITS'(TYPES));
      send_request(KIND_SPARE_FIRST, 0, 0);
      send_request(KIND_SPARE_LAST, '1, '1);
      // clear-source with a bad type still clears the slot
      send_request(KIND_CLR_SRC, SLOT_BITS'(SOURCES - 1), '1);
      send_request(KIND_CLR_ALL, '1, '1);
      wait_idle();
   endtask

   // Global count driven below the slot's count, then clear-source floors at zero
   task automatic test_underflow();
      send_request(KIND_ACQUIRE, 1, 0);
      send_request(KIND_ACQUIRE, 1, 0);
      send_request(KIND_RELEASE, 3, 0);
      send_request(KIND_RELEASE, 3, 0);
      send_request(KIND_CLR_SRC, 1, 0);
      wait_idle();
   endtask

   // Per-source and global denies, and an unlimited type
   task automatic test_deny_causes();
      csr_write(REG_GLOBAL_LIMITS_A, CSR_DW'(3) << (2 * LIMIT_BITS));
      csr_write(REG_GLOBAL_LIMITS_B, '0);
      csr_write(REG_GLOBAL_LIMIT_C, CSR_DW'(LIMIT_TOP));
      csr_write(REG_SOURCE_LIMITS_A, CSR_DW'(2) << (2 * LIMIT_BITS));
      csr_write(REG_SOURCE_LIMITS_B, '0);
      csr_write(REG_SOURCE_LIMIT_C, CSR_DW'(1));
      send_request(KIND_ACQUIRE, 0, 2);
      send_request(KIND_ACQUIRE, 0, 2);
      send_request(KIND_CHECK, 0, 2);
      send_request(KIND_ACQUIRE, 1, 2);
      send_request(KIND_CHECK, 1, 2);
      send_request(KIND_ACQUIRE, 9, TYPE_BITS'(TYPES - 1));
      send_request(KIND_CHECK, 9, TYPE_BITS'(TYPES - 1));
      send_request(KIND_CHECK, 5, 5);
      wait_idle();
   endtask

   // Disabled: everything allowed, no count moves, even on clears
   task automatic test_disabled();
      csr_write(REG_ENABLED, CSR_DW'(2));
      send_request(KIND_ACQUIRE, 0, 2);
      send_request(KIND_CLR_SRC, 0, 2);
      send_request(KIND_CLR_ALL, 0, 2);
      send_request(KIND_CHECK, 1, 2);
      wait_idle();
      csr_write(REG_ENABLED, CSR_DW'(1));
   endtask

   // Long acquire run on one slot, a second slot on the same type, then both cleared
   task automatic test_acquire_run();
      program_limits(LIMS_TOP, LIMS_ZERO);
      send_request(KIND_CLR_ALL, 0, 0);
      repeat (ACQUIRE_RUN) send_request(KIND_ACQUIRE, 5, 7);
      send_request(KIND_CHECK, 5, 7);
      send_request(KIND_ACQUIRE, 6, 7);
      send_request(KIND_ACQUIRE, 6, 7);
      send_request(KIND_CLR_SRC, 5, 7);
      send_request(KIND_CLR_SRC, 6, 7);
      send_request(KIND_CLR_ALL, 0, 0);
      wait_idle();
   endtask

   // Random traffic over several limit settings and idling styles
   task automatic test_random_traffic();
      limit_mode_type       gmodes[4] = '{LIMS_TIGHT, LIMS_ZERO, LIMS_TIGHT, LIMS_ANY};
      limit_mode_type       smodes[4] = '{LIMS_TIGHT, LIMS_TIGHT, LIMS_TOP, LIMS_ZERO};
      int unsigned          send_pcts[4] = '{0, 68, 0, 9};
      int unsigned          stall_pcts[4] = '{0, 0, 68, 9};
      int unsigned          r;
      logic [KIND_BITS-1:0] kind;
      logic [SLOT_BITS-1:0] slot;
      logic [TYPE_BITS-1:0] rtype;
      for (int p = 0; p < 4; p++) begin
         wait_idle();
         program_limits(gmodes[p], smodes[p]);
         send_idle_pct = send_pcts[p];
         recv_stall_pct = stall_pcts[p];
         repeat (RANDOM_REQUESTS) begin
            // mostly acquire/release/check on a few hot slots and types
            r = $urandom_range(99);
            if (r < 30) kind = KIND_CHECK;
            else if (r < 60) kind = KIND_ACQUIRE;
            else if (r < 85) kind = KIND_RELEASE;
            else if (r < 92) kind = KIND_CLR_SRC;
            else if (r < 94) kind = KIND_CLR_ALL;
            else kind = KIND_BITS'($urandom);
            r = $urandom_range(99);
            if (r < 60) slot = SLOT_BITS'($urandom_range(3));
            else if (r < 90) slot = SLOT_BITS'($urandom_range(SOURCES - 1));
            else slot = SLOT_BITS'($urandom);
            r = $urandom_range(99);
            if (r < 60) rtype = TYPE_BITS'($urandom_range(2));
            else if (r < 90) rtype = TYPE_BITS'($urandom_range(TYPES - 1));
            else rtype = TYPE_BITS'($urandom);
            send_request(kind, slot, rtype);
         end
      end
      wait_idle();
   endtask

   initial begin
      // predictor state after reset
      cfg_enabled = 1'b1;
      cfg_glim_a = 60'd84476856107828200;
      cfg_glim_b = 60'd5636372321362020;
      cfg_glim_c = 12'd200;
      cfg_slim_a = 60'd8447685610782820;
      cfg_slim_b = 60'd563637232136202;
      cfg_slim_c = 12'd20;
      for (int i = 0; i < TYPES; i++) begin
         glb_count[i] = '0;
         for (int j = 0; j < SOURCES; j++) src_count[j][i] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_underflow();
      test_deny_causes();
      test_disabled();
      test_acquire_run();
      test_random_traffic();
      wait_idle();

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
